FILE: hdl/fpr_pkg.sv
// Shared constants and types for the FIFO page replacement block.
// No dependencies; every other file imports this package.
package fpr_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int PAGE_W     = 32;
	localparam int SLOT_W     = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int TOTAL_W    = 32;

	localparam logic [CNT_W-1:0] FRAMES_CNT  = CNT_W'(MAX_FRAMES);
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(MAX_FRAMES);

	// One access as it waits in the queue between front and back.
	typedef struct packed {
		logic              valid;
		logic [PAGE_W-1:0] page;
	} fpr_item_t;

	// Result of one access, as held in the output register.
	typedef struct packed {
		logic               hit;
		logic               evicted;
		logic [PAGE_W-1:0]  evicted_page;
		logic [CNT_W-1:0]   resident_count;
		logic               still_cold;
		logic [TOTAL_W-1:0] hit_total;
		logic [TOTAL_W-1:0] miss_total;
	} fpr_result_t;

endpackage

FILE: hdl/fifo_page_replacement_top.sv
// FIFO page replacement: top level joining the input queue and the frame table.
// An accepted beat waits in the input queue until the back end compares it; the result
// is loaded into the output register by the table update, held off by a stalled result.
// The back end finishes one access before comparing the next; the queue can still accept.
// Reset (arst_n low, asynchronous) empties the frame table and the queue,
// zeroes both totals, sets the cold flag and sets frame_limit back to 64.
module fifo_page_replacement_top
	import fpr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CNT_W-1:0]   cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [PAGE_W-1:0]  page_number,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic               evicted,
	output logic [PAGE_W-1:0]  evicted_page,
	output logic [CNT_W-1:0]   resident_count,
	output logic               still_cold,
	output logic [TOTAL_W-1:0] hit_total,
	output logic [TOTAL_W-1:0] miss_total
);

	// The front end only queues beats; the back end owns every piece of
	// table state, so the queue lets new accesses arrive while the back end
	// compares, updates or waits for the output register to drain.
	fpr_item_t   head;
	logic        pop;
	fpr_result_t result;

	fpr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.page_number (page_number),
		.head        (head),
		.pop         (pop)
	);

	// Each access passes through the parallel compare over all frames and
	// then the update, which also loads the output register. The next
	// access is compared only after the table has been updated, so back to
	// back accesses to the same page see each other correctly.
	fpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign hit            = result.hit;
	assign evicted        = result.evicted;
	assign evicted_page   = result.evicted_page;
	assign resident_count = result.resident_count;
	assign still_cold     = result.still_cold;
	assign hit_total      = result.hit_total;
	assign miss_total     = result.miss_total;

endmodule

FILE: hdl/fpr_front.sv
// Input side: accepts access beats into a two-entry queue for the back end.
// Depends on fpr_pkg.
module fpr_front
	import fpr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PAGE_W-1:0] page_number,
	output fpr_item_t         head,
	input  logic              pop
);

	logic [PAGE_W-1:0] entry_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              do_pop;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.page  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= page_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hdl/fpr_back.sv
// Back end: frame table with parallel page compare, FIFO eviction,
// counters and the output register. Depends on fpr_pkg.
module fpr_back
	import fpr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  fpr_item_t        head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output fpr_result_t      result
);

	localparam logic ST_CMP = 1'b0;
	localparam logic ST_UPD = 1'b1;

	logic                  state_q;
	logic [CNT_W-1:0]      frame_limit_q;
	logic [PAGE_W-1:0]     pages_q [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q;
	logic [PAGE_W-1:0]     evict_mem [MAX_FRAMES];
	logic [SLOT_W-1:0]     oldest_q;
	logic [CNT_W-1:0]      present_q;
	logic                  cold_q;
	logic [TOTAL_W-1:0]    hits_q;
	logic [TOTAL_W-1:0]    misses_q;

	logic [MAX_FRAMES-1:0] match_s1;
	logic [PAGE_W-1:0]     page_s1;
	logic [PAGE_W-1:0]     oldest_page_s1;

	logic                  out_valid_q;
	fpr_result_t           result_q;

	logic [MAX_FRAMES-1:0] match;
	logic [CNT_W-1:0]      limit;
	logic                  found;
	logic                  evict;
	logic [SLOT_W-1:0]     ins_slot;
	logic [CNT_W-1:0]      new_count;
	logic                  out_free;
	logic                  commit;
	logic                  miss_commit;

	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign commit    = (state_q == ST_UPD) && out_free;
	assign pop       = commit;

	// Every frame cell compares against the page at the queue head.
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			match[i] = valid_q[i] && (pages_q[i] == head.page);
		end
	end

	always_comb begin
		if (frame_limit_q == '0) begin
			limit = CNT_W'(1);
		end else if (frame_limit_q > FRAMES_CNT) begin
			limit = FRAMES_CNT;
		end else begin
			limit = frame_limit_q;
		end
	end

	assign found       = |match_s1;
	assign evict       = (present_q >= limit);
	assign ins_slot    = oldest_q + present_q[SLOT_W-1:0];
	assign new_count   = evict ? present_q : present_q + CNT_W'(1);
	assign miss_commit = commit && !found;

	// Compare stage and eviction-candidate read.
	always_ff @(posedge clk) begin
		if (state_q == ST_CMP) begin
			match_s1       <= match;
			page_s1        <= head.page;
			oldest_page_s1 <= evict_mem[oldest_q];
		end
	end

	// Page storage: the compare cells and a memory copy for the eviction read.
	always_ff @(posedge clk) begin
		if (miss_commit) begin
			pages_q[ins_slot]   <= page_s1;
			evict_mem[ins_slot] <= page_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q.hit            <= found;
			result_q.evicted        <= !found && evict;
			result_q.evicted_page   <= (!found && evict) ? oldest_page_s1 : '0;
			result_q.resident_count <= found ? present_q : new_count;
			result_q.still_cold     <= found ? cold_q : (cold_q && (new_count < limit));
			result_q.hit_total      <= (found && hits_q != '1) ? hits_q + TOTAL_W'(1) : hits_q;
			result_q.miss_total     <= (!found && misses_q != '1) ?
				misses_q + TOTAL_W'(1) : misses_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CMP;
			frame_limit_q <= LIMIT_RESET;
			valid_q       <= '0;
			oldest_q      <= '0;
			present_q     <= '0;
			cold_q        <= 1'b1;
			hits_q        <= '0;
			misses_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				frame_limit_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_CMP: begin
					if (head.valid) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (commit) begin
						state_q <= ST_CMP;
					end
				end
				default: state_q <= ST_CMP;
			endcase
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (commit && found && hits_q != '1) begin
				hits_q <= hits_q + TOTAL_W'(1);
			end
			if (miss_commit) begin
				if (misses_q != '1) begin
					misses_q <= misses_q + TOTAL_W'(1);
				end
				// Eviction frees the oldest slot; the insert slot is the same
				// one when the table is completely full.
				if (evict) begin
					valid_q[oldest_q] <= 1'b0;
					oldest_q          <= oldest_q + SLOT_W'(1);
				end
				valid_q[ins_slot] <= 1'b1;
				present_q         <= new_count;
				if (new_count >= limit) begin
					cold_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: hdl/fpr_checker.sv
// Port-level checks for the FIFO page replacement block, bound to the top level.
// Depends on fpr_pkg and fifo_page_replacement_top.
module fpr_checker
	import fpr_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               hit,
	input logic               evicted,
	input logic [PAGE_W-1:0]  evicted_page,
	input logic [CNT_W-1:0]   resident_count,
	input logic               still_cold,
	input logic [TOTAL_W-1:0] hit_total
);

	// A stalled result beat stays offered, with its evicted page and hit total unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(evicted_page) && $stable(hit_total))
		else $error("result beat changed while stalled");

	// A hit never evicts and reports no evicted page.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evicted && evicted_page == '0)
		else $error("hit reported an eviction");

	// Every access leaves at least one page resident and never more than the frames.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> resident_count != '0 && resident_count <= FRAMES_CNT)
		else $error("resident count out of range");

	// Once the frames have filled, the cold flag never comes back.
	a_cold_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !still_cold |=> !still_cold)
		else $error("cold flag set again");

endmodule

bind fifo_page_replacement_top fpr_checker u_fpr_checker (.*);
